@@ sv/aes_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES package
// Shared types, register codes, S-box tables and GF(2^8) helpers.
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int unsigned NumRk = 60;
  localparam int unsigned RkAw  = 6;
  localparam int unsigned AddrW = 6;

  localparam logic [2:0] RegKeySize = 3'd0;
  localparam logic [2:0] RegKeyW0   = 3'd1;
  localparam logic [2:0] RegKeyW1   = 3'd2;
  localparam logic [2:0] RegKeyW2   = 3'd3;
  localparam logic [2:0] RegKeyW3   = 3'd4;

  typedef struct packed {
    logic        func;
    logic [63:0] block_hi;
    logic [63:0] block_lo;
  } in_t;

  typedef struct packed {
    logic [63:0] result_hi;
    logic [63:0] result_lo;
  } out_t;

  // Controller -> datapath commands.
  typedef struct packed {
    logic            ks_load;   // load key words into window
    logic            ks_step;   // produce next schedule word
    logic            rk_rd;     // fetch round key word
    logic [RkAw-1:0] rk_addr;
    logic            st_load;   // capture input block
    logic            st_first;  // apply initial whitening
    logic            st_round;  // apply one round
    logic            st_last;   // the round is the final one
    logic            res_load;  // load the output register
    logic            dec;
  } cmd_t;

  typedef struct packed {
    logic [3:0] nk;
    logic [3:0] nr;
  } sts_t;

  localparam logic [7:0] Sbox [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

  localparam logic [7:0] InvSbox [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

endpackage

@@ sv/aes_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES controller
// Sequences key expansion and the per-round datapath operations.
// ----------------------------------------------------------------------------
module aes_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_func_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  logic          sched_clr_i,
  input  aes_pkg::sts_t sts_i,
  output aes_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    StIdle, StKsLoad, StKsRun, StFirst, StRound, StApply, StDone
  } state_e;

  state_e                  state_q, state_d;
  logic                    valid_q, valid_d;
  logic                    dec_q, dec_d;
  logic                    oval_q, oval_d;
  logic [aes_pkg::RkAw-1:0] cnt_q, cnt_d;
  logic [3:0]              rnd_q, rnd_d;
  logic [1:0]              col_q, col_d;

  localparam logic [aes_pkg::RkAw-1:0] LastWord = aes_pkg::RkAw'(aes_pkg::NumRk - 1);

  logic [3:0] rk_round;
  assign rk_round = dec_q ? (sts_i.nr - rnd_q) : rnd_q;

  always_comb begin
    state_d = state_q;
    valid_d = valid_q;
    dec_d   = dec_q;
    oval_d  = oval_q;
    cnt_d   = cnt_q;
    rnd_d   = rnd_q;
    col_d   = col_q;
    cmd_o   = '0;
    cmd_o.dec = dec_q;
    cmd_o.rk_addr = {rk_round, 2'b00} + aes_pkg::RkAw'(col_q);
    if (oval_q && !out_stall_i) oval_d = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.st_load = 1'b1;
          dec_d = in_func_i;
          rnd_d = '0;
          col_d = '0;
          state_d = valid_q ? StFirst : StKsLoad;
        end
      end
      StKsLoad: begin
        cmd_o.ks_load = 1'b1;
        cnt_d = '0;
        state_d = StKsRun;
      end
      StKsRun: begin
        cmd_o.ks_step = 1'b1;
        cmd_o.rk_addr = cnt_q;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == LastWord) begin
          valid_d = 1'b1;
          state_d = StFirst;
        end
      end
      StFirst, StRound: begin
        // Fetch four key words, one per cycle; apply the round once all four are in.
        cmd_o.rk_rd = 1'b1;
        col_d = col_q + 2'd1;
        if (col_q == 2'd3) state_d = StApply;
      end
      StApply: begin
        if (rnd_q == 4'd0) begin
          cmd_o.st_first = 1'b1;
        end else begin
          cmd_o.st_round = 1'b1;
        end
        cmd_o.st_last = (rnd_q == sts_i.nr);
        rnd_d = rnd_q + 4'd1;
        if (rnd_q == sts_i.nr) state_d = StDone;
        else state_d = StRound;
      end
      StDone: begin
        if (!oval_q || !out_stall_i) begin
          cmd_o.res_load = 1'b1;
          oval_d  = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
    if (sched_clr_i) valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      valid_q <= 1'b0;
      dec_q   <= 1'b0;
      oval_q  <= 1'b0;
      cnt_q   <= '0;
      rnd_q   <= '0;
      col_q   <= '0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      dec_q   <= dec_d;
      oval_q  <= oval_d;
      cnt_q   <= cnt_d;
      rnd_q   <= rnd_d;
      col_q   <= col_d;
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = oval_q;

endmodule

@@ sv/aes_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES datapath
// Key schedule store, state register and round function.
// ----------------------------------------------------------------------------
module aes_dp (
  input  logic          clk_i,
  input  logic [1:0]    key_size_i,
  input  logic [255:0]  key_i,
  input  aes_pkg::in_t  in_i,
  input  aes_pkg::cmd_t cmd_i,
  input  logic          out_take_i,
  output aes_pkg::sts_t sts_o,
  output aes_pkg::out_t out_o
);

  logic [3:0] nk;
  assign nk = (key_size_i == 2'd0) ? 4'd4 : (key_size_i == 2'd1) ? 4'd6 : 4'd8;
  assign sts_o.nk = nk;
  assign sts_o.nr = nk + 4'd6;

  logic [31:0] rk_mem [aes_pkg::NumRk];
  logic [31:0] win_q [8];
  logic [3:0]  phase_q;
  logic [7:0]  rc_q;
  logic [31:0] rd_q;
  logic [95:0] kbuf_q;
  logic [127:0] st_q;
  logic [127:0] res_q;

  // Key expansion: window holds the last nk words; win_q[0] is oldest.
  logic [31:0] prev, t, nw, rot;
  logic [3:0]  nkm1;
  assign nkm1 = nk - 4'd1;
  assign prev = win_q[nkm1[2:0]];
  assign rot  = {prev[23:0], prev[31:24]};
  always_comb begin
    t = prev;
    if (phase_q == 4'd0) begin
      t = {aes_pkg::Sbox[rot[31:24]], aes_pkg::Sbox[rot[23:16]],
           aes_pkg::Sbox[rot[15:8]], aes_pkg::Sbox[rot[7:0]]} ^ {rc_q, 24'h0};
    end else if (nk == 4'd8 && phase_q == 4'd4) begin
      t = {aes_pkg::Sbox[prev[31:24]], aes_pkg::Sbox[prev[23:16]],
           aes_pkg::Sbox[prev[15:8]], aes_pkg::Sbox[prev[7:0]]};
    end
    nw = win_q[0] ^ t;
  end

  // The first nk steps write key words directly, the rest computed words.
  logic [5:0] kcnt_q;
  logic       kdirect;
  logic [31:0] kword;
  assign kdirect = (kcnt_q < 6'(nk));
  assign kword = key_i[255 - 32*kcnt_q[2:0] -: 32];

  always_ff @(posedge clk_i) begin
    if (cmd_i.ks_load) begin
      kcnt_q  <= '0;
      phase_q <= '0;
      rc_q    <= 8'h01;
    end else if (cmd_i.ks_step) begin
      kcnt_q <= kcnt_q + 6'd1;
      if (kdirect) begin
        rk_mem[cmd_i.rk_addr] <= kword;
        win_q[kcnt_q[2:0]] <= kword;
      end else begin
        rk_mem[cmd_i.rk_addr] <= nw;
        for (int i = 0; i < 7; i++) begin
          if (3'(i) != nkm1[2:0]) win_q[i] <= win_q[i+1];
        end
        win_q[nkm1[2:0]] <= nw;
        if (phase_q == 4'd0) rc_q <= aes_pkg::xtime(rc_q);
        phase_q <= (phase_q == nkm1) ? 4'd0 : phase_q + 4'd1;
      end
    end
    if (cmd_i.rk_rd) rd_q <= rk_mem[cmd_i.rk_addr];
  end

  // Round function. Key words arrive one per cycle; after the fourth fetch
  // the first three sit in kbuf_q and the fourth in rd_q.
  logic [127:0] rk;
  assign rk = {kbuf_q, rd_q};

  function automatic logic [31:0] mixcol(input logic [31:0] c, input logic inv);
    logic [7:0] b [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m [4];
    logic [7:0] o [4];
    for (int i = 0; i < 4; i++) begin
      b[i]  = c[31-8*i -: 8];
      x2[i] = aes_pkg::xtime(b[i]);
      x4[i] = aes_pkg::xtime(x2[i]);
      x8[i] = aes_pkg::xtime(x4[i]);
    end
    for (int r = 0; r < 4; r++) begin
      if (!inv) begin
        o[r] = x2[r] ^ x2[(r+1)%4] ^ b[(r+1)%4] ^ b[(r+2)%4] ^ b[(r+3)%4];
      end else begin
        m[0] = x8[r] ^ x4[r] ^ x2[r];
        m[1] = x8[(r+1)%4] ^ x2[(r+1)%4] ^ b[(r+1)%4];
        m[2] = x8[(r+2)%4] ^ x4[(r+2)%4] ^ b[(r+2)%4];
        m[3] = x8[(r+3)%4] ^ b[(r+3)%4];
        o[r] = m[0] ^ m[1] ^ m[2] ^ m[3];
      end
    end
    return {o[0], o[1], o[2], o[3]};
  endfunction

  logic [7:0]   sb [16];
  logic [7:0]   sr [16];
  logic [127:0] subsh, mixed, rnd_out;
  always_comb begin
    for (int i = 0; i < 16; i++) sb[i] = st_q[127-8*i -: 8];
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        if (cmd_i.dec) sr[r+4*c] = aes_pkg::InvSbox[sb[r + 4*((c+4-r)%4)]];
        else           sr[r+4*c] = aes_pkg::Sbox[sb[r + 4*((c+r)%4)]];
      end
    end
    for (int i = 0; i < 16; i++) subsh[127-8*i -: 8] = sr[i];
    for (int c = 0; c < 4; c++) begin
      if (cmd_i.dec) begin
        mixed[127-32*c -: 32] = mixcol(subsh[127-32*c -: 32] ^ rk[127-32*c -: 32], 1'b1);
      end else begin
        mixed[127-32*c -: 32] = mixcol(subsh[127-32*c -: 32], 1'b0) ^ rk[127-32*c -: 32];
      end
    end
    rnd_out = cmd_i.st_last ? (subsh ^ rk) : mixed;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rk_rd) kbuf_q <= {kbuf_q[63:0], rd_q};
    if (cmd_i.st_load)       st_q <= {in_i.block_hi, in_i.block_lo};
    else if (cmd_i.st_first) st_q <= st_q ^ rk;
    else if (cmd_i.st_round) st_q <= rnd_out;
    if (out_take_i) res_q <= st_q;
  end

  assign out_o.result_hi = res_q[127:64];
  assign out_o.result_lo = res_q[63:0];

endmodule

@@ sv/aes_block_cipher.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES block cipher
// AES-128/192/256 ECB encrypt and decrypt, one round per cycle group.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries func, block_hi, block_lo.
//   Output channel (out_valid_o / out_stall_i) carries result_hi, result_lo.
//   A transaction moves when valid is high and stall is low at a clock edge.
//   The key and key size are written over the APB port (64-bit data, 8-byte
//   register spacing): key_size, key_w0..key_w3. A write to any of these
//   invalidates the stored schedule; the next block first expands 60 words,
//   one per cycle, after a load step.
//   Per block: each round fetches four key words from the single-port
//   schedule memory, one per cycle, and then applies the round. One block
//   is in flight. AES-128/192/256 use 10 / 12 / 14 rounds.
//   The result sits in an output register; while the receiver stalls it is
//   held and the block waits in its final state before taking the next one.
//   Reset clears the control state and the schedule valid flag; the key
//   registers reset to zero (128-bit key).
// ----------------------------------------------------------------------------
module aes_block_cipher (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  aes_pkg::in_t              in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output aes_pkg::out_t             out_data_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [aes_pkg::AddrW-1:0] paddr,
  input  logic [63:0]               pwdata,
  output logic [63:0]               prdata,
  output logic                      pready
);

  logic [1:0]  key_size_q;
  logic [63:0] key_q [4];
  logic        wr_en;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign wr_en   = psel && penable && pwrite;

  // Register writes; any listed register drops the schedule.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_size_q <= '0;
      for (int i = 0; i < 4; i++) key_q[i] <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        aes_pkg::RegKeySize: key_size_q <= pwdata[1:0];
        aes_pkg::RegKeyW0:   key_q[0] <= pwdata;
        aes_pkg::RegKeyW1:   key_q[1] <= pwdata;
        aes_pkg::RegKeyW2:   key_q[2] <= pwdata;
        aes_pkg::RegKeyW3:   key_q[3] <= pwdata;
        default: ;
      endcase
    end
  end

  logic sched_clr;
  assign sched_clr = wr_en && (reg_idx <= aes_pkg::RegKeyW3);

  always_comb begin
    unique case (reg_idx)
      aes_pkg::RegKeySize: prdata = {62'd0, key_size_q};
      aes_pkg::RegKeyW0:   prdata = key_q[0];
      aes_pkg::RegKeyW1:   prdata = key_q[1];
      aes_pkg::RegKeyW2:   prdata = key_q[2];
      aes_pkg::RegKeyW3:   prdata = key_q[3];
      default:             prdata = '0;
    endcase
  end

  aes_pkg::cmd_t cmd;
  aes_pkg::sts_t sts;
  logic          out_take;
  logic          stall_int;

  aes_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_func_i   (in_data_i.func),
    .in_stall_o  (stall_int),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sched_clr_i (sched_clr),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Load the result register as the final state hands off.
  assign out_take   = cmd.res_load;
  assign in_stall_o = stall_int;

  aes_dp u_dp (
    .clk_i      (clk_i),
    .key_size_i (key_size_q),
    .key_i      ({key_q[0], key_q[1], key_q[2], key_q[3]}),
    .in_i       (in_data_i),
    .cmd_i      (cmd),
    .out_take_i (out_take),
    .sts_o      (sts),
    .out_o      (out_data_o)
  );

  // A pending result holds while stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped under stall");
  // The datapath only rounds or expands keys while the controller is busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.st_round || cmd.ks_step) |-> in_stall_o)
    else $error("datapath active while idle");
  // A round command and a block load never coincide.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.st_load && (cmd.st_round || cmd.st_first)))
    else $error("load overlaps round");

endmodule

@@ tb/aes_block_cipher_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES block cipher testbench
// Drives 128-bit blocks in both directions under 128/192/256-bit keys written
// over the APB port. A local AES model predicts every ciphertext/plaintext;
// the result monitor compares each output transaction against the oldest
// prediction. The sender idles and the receiver stalls at random, with one
// long receiver hold to back the block up.
// ----------------------------------------------------------------------------
module aes_block_cipher_tb;

  localparam int unsigned CycleLimit = 1500000;
  localparam int unsigned SettleCycles = 80;   // quiet time after the last result
  localparam int unsigned LongHold = 400;

  localparam logic FuncEnc = 1'b0;
  localparam logic FuncDec = 1'b1;

  logic          clk_i = 1'b0;
  logic          rst_ni;
  logic          in_valid;
  logic          in_stall;
  aes_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_stall;
  aes_pkg::out_t out_data;
  logic          psel, penable, pwrite;
  logic [aes_pkg::AddrW-1:0] paddr;
  logic [63:0]   pwdata, prdata;
  logic          pready;

  aes_block_cipher dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Shadow of the key registers and the expanded schedule
  // --------------------------------------------------------------------------
  logic [1:0]  key_size_q;
  logic [63:0] key_reg_q [4];
  logic [31:0] round_keys [60];
  logic        schedule_ok;

  aes_pkg::out_t expected_blocks [$];
  int unsigned error_count = 0;
  int unsigned blocks_sent = 0;
  int unsigned blocks_checked = 0;
  int unsigned cycle_count = 0;
  bit          no_idle = 0;      // drop all random gaps and stalls
  bit          long_hold_req = 0;

  function automatic int unsigned key_words();
    int unsigned ks;
    ks = key_size_q;
    if (ks > 2) ks = 2;           // code three saturates to a 256-bit key
    return 4 + 2 * ks;
  endfunction

  function automatic logic [7:0] gf_xtime(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mult(logic [7:0] a, logic [7:0] b);
    logic [7:0] r;
    r = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[0]) r ^= a;
      a = gf_xtime(a);
      b = b >> 1;
    end
    return r;
  endfunction

  function automatic logic [31:0] sub_word32(logic [31:0] w);
    return {aes_pkg::Sbox[w[31:24]], aes_pkg::Sbox[w[23:16]],
            aes_pkg::Sbox[w[15:8]], aes_pkg::Sbox[w[7:0]]};
  endfunction

  function automatic void expand_keys();
    int unsigned nk, total;
    logic [63:0] kr;
    logic [31:0] t;
    logic [7:0]  rc;
    nk = key_words();
    total = 4 * (nk + 7);
    rc = 8'h01;
    for (int unsigned i = 0; i < nk; i++) begin
      kr = key_reg_q[(i >> 1) & 3];
      round_keys[i] = i[0] ? kr[31:0] : kr[63:32];
    end
    for (int unsigned i = nk; i < total && i < 60; i++) begin
      t = round_keys[i-1];
      if (i % nk == 0) begin
        t = sub_word32({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = gf_xtime(rc);
      end else if (nk == 8 && i % 8 == 4) begin
        t = sub_word32(t);
      end
      round_keys[i] = round_keys[i-nk] ^ t;
    end
    schedule_ok = 1'b1;
  endfunction

  // State byte i sits at bits [127-8i -: 8], columns are 32-bit words.
  function automatic logic [127:0] add_key(logic [127:0] s, int unsigned rnd);
    for (int unsigned c = 0; c < 4; c++)
      s[127-32*c -: 32] ^= round_keys[(4*rnd + c) % 60];
    return s;
  endfunction

  function automatic logic [127:0] sub_state(logic [127:0] s, bit inv);
    for (int i = 0; i < 16; i++)
      s[127-8*i -: 8] = inv ? aes_pkg::InvSbox[s[127-8*i -: 8]]
                            : aes_pkg::Sbox[s[127-8*i -: 8]];
    return s;
  endfunction

  function automatic logic [127:0] shift_state(logic [127:0] s, bit inv);
    logic [127:0] t;
    int unsigned src;
    t = s;
    for (int unsigned r = 0; r < 4; r++)
      for (int unsigned c = 0; c < 4; c++) begin
        src = r + 4 * ((inv ? (c + 4 - r) : (c + r)) % 4);
        s[127-8*(r+4*c) -: 8] = t[127-8*src -: 8];
      end
    return s;
  endfunction

  function automatic logic [127:0] mix_state(logic [127:0] s, bit inv);
    logic [7:0] col [4];
    logic [7:0] coef [4];
    logic [7:0] v;
    if (inv) coef = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
    else     coef = '{8'h02, 8'h03, 8'h01, 8'h01};
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) col[r] = s[127-8*(4*c+r) -: 8];
      for (int r = 0; r < 4; r++) begin
        v = 8'h00;
        for (int j = 0; j < 4; j++) v ^= gf_mult(coef[j], col[(r+j)%4]);
        s[127-8*(4*c+r) -: 8] = v;
      end
    end
    return s;
  endfunction

  function automatic aes_pkg::out_t aes_transform(aes_pkg::in_t x);
    logic [127:0] s;
    int unsigned nr;
    aes_pkg::out_t o;
    if (!schedule_ok) expand_keys();
    nr = key_words() + 6;
    s = {x.block_hi, x.block_lo};
    if (x.func == FuncEnc) begin
      s = add_key(s, 0);
      for (int unsigned r = 1; r < nr; r++)
        s = add_key(mix_state(shift_state(sub_state(s, 0), 0), 0), r);
      s = add_key(shift_state(sub_state(s, 0), 0), nr);
    end else begin
      s = add_key(s, nr);
      for (int unsigned r = nr - 1; r > 0; r--)
        s = mix_state(add_key(sub_state(shift_state(s, 1), 1), r), 1);
      s = add_key(sub_state(shift_state(s, 1), 1), 0);
    end
    o.result_hi = s[127:64];
    o.result_lo = s[63:0];
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // Bus and channel drivers
  // --------------------------------------------------------------------------

  // Write one register with a setup and an access phase; update the shadow.
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      aes_pkg::RegKeySize: begin
        key_size_q  = val[1:0];
        schedule_ok = 1'b0;
      end
      aes_pkg::RegKeyW0, aes_pkg::RegKeyW1, aes_pkg::RegKeyW2, aes_pkg::RegKeyW3: begin
        key_reg_q[idx - aes_pkg::RegKeyW0] = val;
        schedule_ok = 1'b0;
      end
      default: ;   // unmapped index: nothing changes
    endcase
    @(posedge clk_i);
  endtask

  // Drop the input, wait until every prediction has been matched, then settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_blocks.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic load_key(input logic [1:0] ks, input logic [63:0] k0, input logic [63:0] k1,
                          input logic [63:0] k2, input logic [63:0] k3);
    wait_idle();
    write_reg(aes_pkg::RegKeySize, {62'h0, ks});
    write_reg(aes_pkg::RegKeyW0, k0);
    write_reg(aes_pkg::RegKeyW1, k1);
    write_reg(aes_pkg::RegKeyW2, k2);
    write_reg(aes_pkg::RegKeyW3, k3);
  endtask

  // Offer one block; return at the edge where the transaction moves.
  task automatic send_block(input logic func, input logic [63:0] hi, input logic [63:0] lo);
    int unsigned gap;
    aes_pkg::in_t item;
    gap = no_idle ? 0 : $urandom_range(0, 16);
    item.func = func;
    item.block_hi = hi;
    item.block_lo = lo;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    forever begin
      @(negedge clk_i);
      if (!in_stall) break;
    end
    expected_blocks.push_back(aes_transform(item));
    blocks_sent++;
    @(posedge clk_i);
  endtask

  task automatic end_stream();
    in_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // --------------------------------------------------------------------------
  // Result receiver and checker
  // --------------------------------------------------------------------------
  initial begin
    int unsigned n;
    forever begin
      if (long_hold_req) begin
        out_stall <= 1'b1;
        repeat (LongHold) @(posedge clk_i);
        long_hold_req = 0;
      end
      n = no_idle ? 0 : $urandom_range(0, 16);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      do @(negedge clk_i); while (!(out_valid && !out_stall));
      @(posedge clk_i);
    end
  end

  // Judge transactions mid-cycle, where every signal is settled.
  always @(negedge clk_i) begin
    aes_pkg::out_t exp_blk;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_blocks.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        error_count++;
      end else begin
        exp_blk = expected_blocks.pop_front();
        blocks_checked++;
        if (out_data.result_hi !== exp_blk.result_hi) begin
          $display("%0t: result_hi expected %h actual %h", $time,
                   exp_blk.result_hi, out_data.result_hi);
          error_count++;
        end
        if (out_data.result_lo !== exp_blk.result_lo) begin
          $display("%0t: result_lo expected %h actual %h", $time,
                   exp_blk.result_lo, out_data.result_lo);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout, %0d blocks outstanding", $time, expected_blocks.size());
      $display("tb: failure");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Each key size with all-zero, all-one and alternating keys and blocks.
  task automatic test_key_extremes();
    logic [63:0] pat [3];
    pat = '{64'h0, 64'hffff_ffff_ffff_ffff, 64'haaaa_5555_aaaa_5555};
    for (int ks = 0; ks < 3; ks++) begin
      load_key(ks[1:0], pat[ks], pat[(ks+1)%3], pat[(ks+2)%3], pat[ks]);
      send_block(FuncEnc, pat[ks], pat[(ks+1)%3]);
      send_block(FuncDec, pat[(ks+2)%3], pat[ks]);
      send_block(FuncEnc, 64'hffff_ffff_ffff_ffff, 64'h0);
      send_block(FuncDec, 64'h0, 64'hffff_ffff_ffff_ffff);
    end
  endtask

  // Key size three saturates; unused key words must not matter.
  task automatic test_special_cases();
    load_key(2'd3, 64'h0001_0203_0405_0607, 64'h0809_0a0b_0c0d_0e0f,
             64'h1011_1213_1415_1617, 64'h1819_1a1b_1c1d_1e1f);
    send_block(FuncEnc, 64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
    send_block(FuncDec, 64'h8ea2_b7ca_5167_45bf, 64'heafc_4990_4b49_6089);
    // 128-bit key with garbage in the upper key words
    load_key(2'd0, 64'h0001_0203_0405_0607, 64'h0809_0a0b_0c0d_0e0f,
             64'hdead_beef_dead_beef, 64'hffff_ffff_ffff_ffff);
    send_block(FuncEnc, 64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
    // unmapped index: the schedule stays valid
    wait_idle();
    write_reg(3'd5, 64'h3);
    write_reg(3'd7, 64'hffff_ffff_ffff_ffff);
    send_block(FuncDec, 64'h69c4_e0d8_6a7b_0430, 64'hd8cd_b780_70b4_c55a);
    // rewriting the same value still forces a fresh expansion
    wait_idle();
    write_reg(aes_pkg::RegKeyW0, key_reg_q[0]);
    send_block(FuncEnc, 64'h0, 64'h0);
    end_stream();
  endtask

  // Random keys and blocks in phases; one phase with no idling.
  task automatic test_random_traffic();
    for (int ph = 0; ph < 13; ph++) begin
      load_key((ph < 4) ? ph[1:0] : 2'($urandom_range(0, 3)), rand64(), rand64(),
               rand64(), rand64());
      no_idle = (ph == 6);
      for (int i = 0; i < 100; i++)
        send_block(1'($urandom_range(0, 1)), rand64(), rand64());
      end_stream();
      no_idle = 0;
    end
  endtask

  // Hold the receiver off while the sender streams back to back.
  task automatic test_backpressure();
    load_key(2'd2, rand64(), rand64(), rand64(), rand64());
    long_hold_req = 1;
    no_idle = 1;
    for (int i = 0; i < 30; i++)
      send_block(1'($urandom_range(0, 1)), rand64(), rand64());
    end_stream();
    no_idle = 0;
  endtask

  initial begin
    rst_ni   <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    key_size_q  = 2'd0;
    key_reg_q   = '{default: 64'h0};
    schedule_ok = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset key: all-zero 128-bit key, expanded on the first block
    send_block(FuncEnc, 64'h0, 64'h0);
    test_key_extremes();
    test_special_cases();
    test_backpressure();
    test_random_traffic();

    wait_idle();
    $display("Sent %0d blocks, checked %0d results, key sizes 128/192/256 and code 3,",
             blocks_sent, blocks_checked);
    $display("both directions, random gaps and stalls, one long output hold.");
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", error_count);
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ aes_block_cipher.f @@
sv/aes_pkg.sv
sv/aes_ctrl.sv
sv/aes_dp.sv
sv/aes_block_cipher.sv
tb/aes_block_cipher_tb.sv
